// File: rtl/car_pkg.sv
`default_nettype none
// ============================================================================
// car_pkg: shared types, constants and tables for the comb/allpass reverb
// Fixed-point formats, preset tables, payload and control structs, and the
// saturation helpers used by the line and mix datapaths.
// ============================================================================
package car_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W    = 16;  // Q1.15 audio sample
  localparam int LINE_W      = 24;  // Q4.20 line entry
  localparam int LSUM_W      = 26;  // headroom for line sums before saturation
  localparam int DELAY_W     = 12;  // longest tap is below 4096
  localparam int DECAY_W     = 15;  // Q0.15 decay, always below 1.0
  localparam int WET_W       = 16;  // Q1.15 wet level, 32768 is 1.0
  localparam int PRESET_W    = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_COMBS   = 4;
  localparam int NUM_AP      = 2;
  localparam int NUM_PRESETS = 6;
  localparam int ROW_W       = 3;   // index into the preset tables

  // Mix accumulator and rounding
  localparam int ACC_W   = 42;
  localparam int DRY_P_W = 33;      // sample x dry gain
  localparam int WET_P_W = 41;      // reverb x wet level

  // Register codes
  typedef enum logic [0:0] {
    REG_PRESET = 1'b0,
    REG_WET    = 1'b1
  } car_reg_t;

  localparam logic [PRESET_W-1:0] PRESET_BYPASS = 3'd0;
  localparam logic [PRESET_W-1:0] PRESET_PLATE  = 3'd6;
  localparam logic [WET_W-1:0]    WET_ONE       = 16'd32768;
  localparam logic [WET_W-1:0]    WET_MIN       = 16'd328;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [LINE_W-1:0]   line_t;

  // Payloads
  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    block_end_in;
  } car_in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    logic    block_end_out;
  } car_out_t;

  // Dry frame carried along the pipeline next to the wet path
  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    block_end;
    logic    bypass;
  } car_dry_t;

  // Per-line memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;   // write zero instead of the computed entry
  } car_line_ctl_t;

  // Mix stage load enables
  typedef struct packed {
    logic ld_prod;
    logic ld_out;
  } car_mix_ctl_t;

  // Preset tables, rows are presets 1..6
  localparam logic [DELAY_W-1:0] COMB_DELAY_TAB [NUM_PRESETS][NUM_COMBS] = '{
    '{12'd557,  12'd617,  12'd709,  12'd811},
    '{12'd1117, 12'd1277, 12'd1487, 12'd1687},
    '{12'd1557, 12'd1777, 12'd2087, 12'd2387},
    '{12'd2001, 12'd2287, 12'd2647, 12'd3001},
    '{12'd2777, 12'd3167, 12'd3607, 12'd4091},
    '{12'd1367, 12'd1559, 12'd1783, 12'd2017}
  };

  localparam logic [DECAY_W-1:0] COMB_DECAY_TAB [NUM_PRESETS][NUM_COMBS] = '{
    '{15'd22938, 15'd22282, 15'd21627, 15'd20972},
    '{15'd25559, 15'd24904, 15'd24248, 15'd23593},
    '{15'd26870, 15'd26214, 15'd25559, 15'd24904},
    '{15'd28180, 15'd27525, 15'd26870, 15'd26214},
    '{15'd29491, 15'd28836, 15'd28180, 15'd27525},
    '{15'd30147, 15'd29819, 15'd29491, 15'd29164}
  };

  localparam logic [DELAY_W-1:0] AP_DELAY_TAB [NUM_PRESETS][NUM_AP] = '{
    '{12'd113, 12'd271},
    '{12'd211, 12'd379},
    '{12'd307, 12'd491},
    '{12'd403, 12'd607},
    '{12'd509, 12'd797},
    '{12'd157, 12'd331}
  };

  // Table row for a preset; the unused top code maps onto plate
  function automatic logic [ROW_W-1:0] preset_row(input logic [PRESET_W-1:0] preset);
    logic [ROW_W-1:0] row;
    case (preset) inside
      3'd6, 3'd7: row = ROW_W'(NUM_PRESETS - 1);
      3'd0:       row = '0;
      default:    row = preset - 3'd1;
    endcase
    return row;
  endfunction

  // Saturate a widened line sum to the 24-bit line format
  function automatic line_t sat_line(input logic signed [LSUM_W-1:0] v);
    line_t r;
    if (v > LSUM_W'(signed'({1'b0, {(LINE_W-1){1'b1}}}))) begin
      r = {1'b0, {(LINE_W-1){1'b1}}};
    end else if (v < -LSUM_W'(signed'({1'b0, 1'b1, {(LINE_W-1){1'b0}}}))) begin
      r = {1'b1, {(LINE_W-1){1'b0}}};
    end else begin
      r = v[LINE_W-1:0];
    end
    return r;
  endfunction

  // Saturate a rounded mix result to a 16-bit sample
  function automatic sample_t sat_sample(input logic signed [ACC_W-21:0] v);
    sample_t r;
    if (v > (ACC_W-20)'(32'sd32767)) begin
      r = 16'sh7FFF;
    end else if (v < (ACC_W-20)'(-32'sd32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage : car_pkg
`default_nettype wire

// File: rtl/car_ram.sv
`default_nettype none
// ============================================================================
// car_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ============================================================================
module car_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : car_ram
`default_nettype wire

// File: rtl/car_comb_bank.sv
`default_nettype none
// ============================================================================
// car_comb_bank: four parallel feedback comb lines
// Each line reads its delayed tap, scales it by the preset decay and writes
// back input plus the rounded product. Outputs the floor average of taps.
// ============================================================================
module car_comb_bank #(
  parameter int LINE_DEPTH = 8192
) (
  input  logic                          clk,
  input  car_pkg::car_line_ctl_t        ctl,
  input  logic [car_pkg::ROW_W-1:0]     row,
  input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr [car_pkg::NUM_COMBS],
  input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
  input  car_pkg::line_t                mono,
  output car_pkg::line_t                avg
);
  import car_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  line_t                   tap    [NUM_COMBS];
  line_t                   wr_val [NUM_COMBS];
  logic signed [LSUM_W-1:0] tap_sum;

  for (genvar i = 0; i < NUM_COMBS; i++) begin : g_line
    logic [LINE_W-1:0]                 rd_raw;
    logic signed [LINE_W+DECAY_W:0]    prod_full;
    logic signed [LINE_W:0]            prod;
    logic [LINE_W-1:0]                 wr_data;

    car_ram #(
      .WIDTH(LINE_W),
      .DEPTH(LINE_DEPTH)
    ) u_ram (
      .clk    (clk),
      .wr_en  (ctl.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctl.rd_en),
      .rd_addr(rd_addr[i]),
      .rd_data(rd_raw)
    );

    assign tap[i] = rd_raw;

    // tap * decay, rounded half up, floor shift by 15
    assign prod_full = tap[i] * signed'({1'b0, COMB_DECAY_TAB[row][i]})
                       + (LINE_W+DECAY_W+1)'(16384);
    assign prod      = prod_full[LINE_W+DECAY_W:DECAY_W];

    assign wr_val[i] = sat_line(LSUM_W'(mono) + LSUM_W'(prod));
    assign wr_data   = ctl.clear ? '0 : wr_val[i];
  end

  // Floor average of the four taps
  assign tap_sum = LSUM_W'(tap[0]) + LSUM_W'(tap[1]) + LSUM_W'(tap[2]) + LSUM_W'(tap[3]);
  assign avg     = tap_sum[LINE_W+1:2];

endmodule : car_comb_bank
`default_nettype wire

// File: rtl/car_allpass.sv
`default_nettype none
// ============================================================================
// car_allpass: one allpass stage with gain one half
// Output is the delayed entry minus half the input; the line takes the
// input plus half the output, both saturated to the line format.
// ============================================================================
module car_allpass #(
  parameter int LINE_DEPTH = 8192
) (
  input  logic                          clk,
  input  car_pkg::car_line_ctl_t        ctl,
  input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
  input  car_pkg::line_t                x,
  output car_pkg::line_t                y
);
  import car_pkg::*;

  logic [LINE_W-1:0] rd_raw;
  logic [LINE_W-1:0] wr_data;
  line_t             tap;
  line_t             wr_val;

  car_ram #(
    .WIDTH(LINE_W),
    .DEPTH(LINE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign tap = rd_raw;

  // Feedforward out, then feedback into the line
  assign y       = sat_line(LSUM_W'(tap) - LSUM_W'(x >>> 1));
  assign wr_val  = sat_line(LSUM_W'(x) + LSUM_W'(y >>> 1));
  assign wr_data = ctl.clear ? '0 : wr_val;

endmodule : car_allpass
`default_nettype wire

// File: rtl/car_mix.sv
`default_nettype none
// ============================================================================
// car_mix: dry/wet mixer and output register
// First stage registers the dry and wet products, second stage sums,
// rounds and saturates each channel into the output item; bypass copies dry.
// ============================================================================
module car_mix #(
  parameter int CHANNELS = 2
) (
  input  logic                      clk,
  input  car_pkg::car_mix_ctl_t     ctl,
  input  logic [car_pkg::WET_W-1:0] wet,
  input  car_pkg::car_dry_t         dry,
  input  car_pkg::line_t            rev,
  output car_pkg::car_out_t         result
);
  import car_pkg::*;

  logic [WET_W-1:0]          dry_gain;
  logic signed [DRY_P_W-1:0] prod_l;
  logic signed [DRY_P_W-1:0] prod_r;
  logic signed [WET_P_W-1:0] prod_w;
  car_dry_t                  dry_q;
  logic signed [ACC_W-1:0]   acc_l;
  logic signed [ACC_W-1:0]   acc_r;
  sample_t                   mix_l;
  sample_t                   mix_r;

  // Dry gain is one minus half the wet level
  assign dry_gain = WET_ONE - {1'b0, wet[WET_W-1:1]};

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_l <= dry.left * signed'({1'b0, dry_gain});
      prod_r <= dry.right * signed'({1'b0, dry_gain});
      prod_w <= rev * signed'({1'b0, wet});
      dry_q  <= dry;
    end
  end

  // Sum in Q.35 with round bias, floor shift by 20
  assign acc_l = (ACC_W'(prod_l) <<< 5) + ACC_W'(prod_w) + ACC_W'(524288);
  assign acc_r = (ACC_W'(prod_r) <<< 5) + ACC_W'(prod_w) + ACC_W'(524288);
  assign mix_l = sat_sample(acc_l[ACC_W-1:20]);
  assign mix_r = sat_sample(acc_r[ACC_W-1:20]);

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      result.block_end_out <= dry_q.block_end;
      if (dry_q.bypass) begin
        result.left_out  <= dry_q.left;
        result.right_out <= dry_q.right;
      end else begin
        result.left_out  <= mix_l;
        result.right_out <= (CHANNELS == 2) ? mix_r : '0;
      end
    end
  end

endmodule : car_mix
`default_nettype wire

// File: rtl/comb_allpass_reverb_core.sv
`default_nettype none
// Throughput: one item per cycle while neither result_stall nor the clearing pass
// holds the pipeline; each line RAM does one read and one write per cycle.
// Reset: rst clears control state and configuration, then a clearing pass zeroes all
// six lines, during which frame_stall stays high.
// Configuration writes are taken in every cycle, including during the clearing pass.
// ============================================================================
// comb_allpass_reverb_core: stereo Schroeder reverb, four combs and two allpasses
// Six line RAMs share one write position. Pipeline: comb taps, allpass one,
// allpass two, mix products, output register. Taps lie at least 113 entries
// behind the write position, so no read can meet a write still in flight.
// ============================================================================
module comb_allpass_reverb_core #(
  parameter int LINE_DEPTH = 8192,
  parameter int CHANNELS   = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           frame_valid,
  output logic                           frame_stall,
  input  car_pkg::car_in_t               frame,
  // result items
  output logic                           result_valid,
  input  logic                           result_stall,
  output car_pkg::car_out_t              result,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  car_pkg::car_reg_t              cfg_index,
  input  logic [car_pkg::CFG_DATA_W-1:0] cfg_data
);
  import car_pkg::*;

  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int NSTAGE = 6;
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(LINE_DEPTH);
  localparam logic [AW-1:0] LAST_POS  = AW'(LINE_DEPTH - 1);

  // Tap address: pos - dly modulo the line depth
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0]      pos,
                                              input logic [DELAY_W-1:0] dly);
    logic [AW:0] t;
    t = {1'b0, pos} + DEPTH_EXT - (AW+1)'(dly);
    if (t >= DEPTH_EXT) begin
      t = t - DEPTH_EXT;
    end
    return t[AW-1:0];
  endfunction

  // Configuration and position state
  logic [PRESET_W-1:0] preset;
  logic [WET_W-1:0]    wet_mix;
  logic [WET_W-1:0]    wet_eff;
  logic [ROW_W-1:0]    row;
  logic                bypass_now;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       pos_next;
  logic                clearing;
  logic [AW-1:0]       clr_addr;

  // Pipeline handshake
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] free;
  logic [NSTAGE-1:0] go;
  logic              accept;

  // Stage data
  car_dry_t      in_dry;
  line_t         in_mono;
  car_dry_t      c_dry;
  line_t         c_mono;
  logic [AW-1:0] c_pos;
  car_dry_t      a1_dry;
  line_t         a1_avg;
  logic [AW-1:0] a1_pos;
  car_dry_t      a2_dry;
  line_t         a2_x;
  logic [AW-1:0] a2_pos;
  car_dry_t      rv_dry;
  line_t         rv_rev;

  // Datapath wiring
  car_line_ctl_t comb_ctl;
  car_line_ctl_t ap1_ctl;
  car_line_ctl_t ap2_ctl;
  car_mix_ctl_t  mix_ctl;
  logic [AW-1:0] comb_rd_addr [NUM_COMBS];
  logic [AW-1:0] comb_wr_addr;
  logic [AW-1:0] ap1_rd_addr;
  logic [AW-1:0] ap1_wr_addr;
  logic [AW-1:0] ap2_rd_addr;
  logic [AW-1:0] ap2_wr_addr;
  line_t         comb_avg;
  line_t         ap1_y;
  line_t         ap2_y;

  // Configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preset  <= PRESET_BYPASS;
      wet_mix <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESET: preset  <= cfg_data[PRESET_W-1:0];
        REG_WET:    wet_mix <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign wet_eff    = (wet_mix > WET_ONE) ? WET_ONE : wet_mix;
  assign row        = preset_row(preset);
  assign bypass_now = (preset == PRESET_BYPASS) || (wet_mix < WET_MIN);

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_POS) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Elastic pipeline: a stage moves when the one after it has room
  always_comb begin
    free[NSTAGE-1] = !vld[NSTAGE-1] || !result_stall;
    go[NSTAGE-1]   = vld[NSTAGE-1] && !result_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
      go[k]   = vld[k] && free[k+1];
    end
  end

  assign frame_stall  = clearing || !free[0];
  assign accept       = frame_valid && !frame_stall;
  assign result_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= accept || (vld[0] && !go[0]);
      for (int k = 1; k < NSTAGE; k++) begin
        vld[k] <= go[k-1] || (vld[k] && !go[k]);
      end
    end
  end

  // Write position advances once per accepted item that is not bypassed
  assign pos_next = (pos == LAST_POS) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept && !bypass_now) begin
      pos <= pos_next;
    end
  end

  // Input capture: mono mix in Q4.20
  always_comb begin
    in_dry.left      = frame.left_in;
    in_dry.right     = (CHANNELS == 2) ? frame.right_in : '0;
    in_dry.block_end = frame.block_end_in;
    in_dry.bypass    = bypass_now;
    if (CHANNELS == 2) begin
      in_mono = (LINE_W'(frame.left_in) + LINE_W'(frame.right_in)) <<< 4;
    end else begin
      in_mono = LINE_W'(frame.left_in) <<< 5;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (accept) begin
      c_dry  <= in_dry;
      c_mono <= in_mono;
      c_pos  <= pos;
    end
    if (go[0]) begin
      a1_dry <= c_dry;
      a1_avg <= comb_avg;
      a1_pos <= c_pos;
    end
    if (go[1]) begin
      a2_dry <= a1_dry;
      a2_x   <= ap1_y;
      a2_pos <= a1_pos;
    end
    if (go[2]) begin
      rv_dry <= a2_dry;
      rv_rev <= ap2_y;
    end
  end

  // Comb taps are read as the item enters
  for (genvar i = 0; i < NUM_COMBS; i++) begin : g_comb_addr
    assign comb_rd_addr[i] = back_addr(pos, COMB_DELAY_TAB[row][i]);
  end

  assign comb_ctl.rd_en  = accept;
  assign comb_ctl.wr_en  = clearing || (go[0] && !c_dry.bypass);
  assign comb_ctl.clear  = clearing;
  assign comb_wr_addr    = clearing ? clr_addr : c_pos;

  assign ap1_ctl.rd_en   = go[0];
  assign ap1_ctl.wr_en   = clearing || (go[1] && !a1_dry.bypass);
  assign ap1_ctl.clear   = clearing;
  assign ap1_rd_addr     = back_addr(c_pos, AP_DELAY_TAB[row][0]);
  assign ap1_wr_addr     = clearing ? clr_addr : a1_pos;

  assign ap2_ctl.rd_en   = go[1];
  assign ap2_ctl.wr_en   = clearing || (go[2] && !a2_dry.bypass);
  assign ap2_ctl.clear   = clearing;
  assign ap2_rd_addr     = back_addr(a1_pos, AP_DELAY_TAB[row][1]);
  assign ap2_wr_addr     = clearing ? clr_addr : a2_pos;

  assign mix_ctl.ld_prod = go[3];
  assign mix_ctl.ld_out  = go[4];

  car_comb_bank #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_comb (
    .clk    (clk),
    .ctl    (comb_ctl),
    .row    (row),
    .rd_addr(comb_rd_addr),
    .wr_addr(comb_wr_addr),
    .mono   (c_mono),
    .avg    (comb_avg)
  );

  car_allpass #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ap1 (
    .clk    (clk),
    .ctl    (ap1_ctl),
    .rd_addr(ap1_rd_addr),
    .wr_addr(ap1_wr_addr),
    .x      (a1_avg),
    .y      (ap1_y)
  );

  car_allpass #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ap2 (
    .clk    (clk),
    .ctl    (ap2_ctl),
    .rd_addr(ap2_rd_addr),
    .wr_addr(ap2_wr_addr),
    .x      (a2_x),
    .y      (ap2_y)
  );

  car_mix #(
    .CHANNELS(CHANNELS)
  ) u_mix (
    .clk   (clk),
    .ctl   (mix_ctl),
    .wet   (wet_eff),
    .dry   (rv_dry),
    .rev   (rv_rev),
    .result(result)
  );

endmodule : comb_allpass_reverb_core
`default_nettype wire
